// ===== rtl/cpcr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpcr_pkg
// Word types and fixed widths shared by the circle pair resolve block.
// ----------------------------------------------------------------------------
package cpcr_pkg;

    localparam int POS_W  = 32;
    localparam int RAD_W  = 31;
    localparam int IM_W   = 24;
    localparam int REST_W = 32;
    localparam int DM_W   = 32;
    localparam int Q1_B   = 39;
    localparam int LEN_W  = 38;
    localparam int CORR_W = 33;

    typedef struct packed {
        logic                    mode;
        logic signed [POS_W-1:0] a_pos_x;
        logic signed [POS_W-1:0] a_pos_y;
        logic signed [POS_W-1:0] a_pos_z;
        logic signed [POS_W-1:0] b_pos_x;
        logic signed [POS_W-1:0] b_pos_y;
        logic signed [POS_W-1:0] b_pos_z;
        logic [RAD_W-1:0]        a_radius;
        logic [RAD_W-1:0]        b_radius;
        logic [IM_W-1:0]         a_inv_mass;
        logic [IM_W-1:0]         b_inv_mass;
        logic [RAD_W-1:0]        rod_length;
    } t_req;

    typedef struct packed {
        logic signed [POS_W-1:0] new_a_x;
        logic signed [POS_W-1:0] new_a_y;
        logic signed [POS_W-1:0] new_a_z;
        logic signed [POS_W-1:0] new_b_x;
        logic signed [POS_W-1:0] new_b_y;
        logic signed [POS_W-1:0] new_b_z;
        logic                    hit;
    } t_rsp;

endpackage

// ===== rtl/cpcr_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpcr_req_if
// Request channel: valid, ready and one body pair word.
// ----------------------------------------------------------------------------
interface cpcr_req_if;
    import cpcr_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/cpcr_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpcr_rsp_if
// Response channel: valid, ready and one corrected pair word.
// ----------------------------------------------------------------------------
interface cpcr_rsp_if;
    import cpcr_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/cpcr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpcr_div
// Pipelined restoring divider, one quotient bit per stage, with overflow
// flag when the quotient does not fit QB bits. Side data rides along.
// ----------------------------------------------------------------------------
module cpcr_div #(
    parameter int NW = 66,
    parameter int DW = 32,
    parameter int QB = 39,
    parameter int TW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [TW-1:0] i_tag,
    output logic          o_vld,
    output logic [QB-1:0] o_quot,
    output logic          o_ovf,
    output logic [TW-1:0] o_tag
);

    localparam int NS = QB + 1;
    localparam int CW = (NW > DW) ? NW : DW;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] r_ovf;
    logic [DW-1:0] r_rem [NS];
    logic [QB-1:0] r_lo  [NS];
    logic [QB-1:0] r_q   [NS];
    logic [DW-1:0] r_den [NS];
    logic [TW-1:0] r_tag [NS];

    logic [CW-1:0] n_hi;
    logic          n_ovf;

    always_comb begin
        n_hi  = CW'(i_num >> QB);
        n_ovf = n_hi >= CW'(i_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0] <= n_ovf;
            r_rem[0] <= n_ovf ? '0 : DW'(i_num >> QB);
            r_lo[0]  <= i_num[QB-1:0];
            r_q[0]   <= '0;
            r_den[0] <= i_den;
            r_tag[0] <= i_tag;
        end
    end

    for (genvar k = 1; k < NS; k++) begin : g_step
        logic [DW:0] n_t;
        logic [DW:0] n_d;
        logic        n_ge;

        always_comb begin
            n_t  = {r_rem[k-1], r_lo[k-1][QB-k]};
            n_d  = n_t - {1'b0, r_den[k-1]};
            n_ge = n_t >= {1'b0, r_den[k-1]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ovf[k] <= r_ovf[k-1];
                r_rem[k] <= n_ge ? n_d[DW-1:0] : n_t[DW-1:0];
                r_lo[k]  <= r_lo[k-1];
                r_q[k]   <= n_ge ? (r_q[k-1] | (QB'(1) << (QB - k))) : r_q[k-1];
                r_den[k] <= r_den[k-1];
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    assign o_vld  = r_vld[NS-1];
    assign o_quot = r_q[NS-1];
    assign o_ovf  = r_ovf[NS-1];
    assign o_tag  = r_tag[NS-1];

endmodule

// ===== rtl/circle_pair_collision_resolve.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_pair_collision_resolve
// Path: registered stages A, B and C, the length divider, stages D, E and F,
// the two parallel scale dividers, and stages G and O.
// Throughput: one word per cycle while the skid is empty; a one-word skid holds a stalled response and stalls the pipe.
// Reset: synchronous active-low reset clears all valid bits, the skid's valid flag included.
// ----------------------------------------------------------------------------
module circle_pair_collision_resolve
    import cpcr_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cpcr_req_if.sink    i_req,
    cpcr_rsp_if.source  o_rsp
);

    localparam int F       = FRAC_BITS;
    localparam int EPS_Q   = ((1 << F) + 5000) / 10000;
    localparam int EPS_RAW = (EPS_Q == 0) ? 1 : EPS_Q;
    localparam int DSQ_W   = 2 * DM_W + 2 - F;
    localparam int N1_W    = 2 * DM_W + 2;
    localparam int IMW_W   = IM_W + 1;
    localparam int LH_W    = LEN_W / 2;
    localparam int LL_W    = LEN_W - LH_W;
    localparam int PL_W    = LH_W + IMW_W;
    localparam int PN_W    = LH_W + IM_W;
    localparam int LW_W    = LEN_W + IMW_W;
    localparam int DEN_W   = LW_W - F + 1;
    localparam int N2_W    = LEN_W + IM_W;
    localparam int Q2_B    = F + 2;
    localparam int PR_W    = Q2_B + DM_W;
    localparam logic [Q2_B-1:0]  S_CAP = Q2_B'(1) << (F + 1);
    localparam logic [LEN_W-1:0] L_CAP = '1;

    typedef struct packed {
        logic [2:0][POS_W-1:0] pa;
        logic [2:0][POS_W-1:0] pb;
        logic [2:0][DM_W-1:0]  dm;
        logic [2:0]            dn;
    } t_posd;

    typedef struct packed {
        logic              mode;
        logic [REST_W-1:0] rest;
        t_posd             p;
        logic [IM_W-1:0]   ima;
        logic [IM_W-1:0]   imb;
    } t_car;

    typedef struct packed {
        t_car c;
        logic [2:0][2*DM_W-1:0] sq;
        logic [2*REST_W-1:0]    rr;
    } t_sb;

    typedef struct packed {
        t_car             c;
        logic [DSQ_W-1:0] dsq;
        logic             dle;
    } t_sc;

    typedef struct packed {
        t_car c;
        logic dle;
    } t_tg1;

    typedef struct packed {
        t_posd            p;
        logic             hit;
        logic             nneg;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] nmag;
        logic [IM_W-1:0]  ima;
        logic [IM_W-1:0]  imb;
        logic [IMW_W-1:0] w;
    } t_sd;

    typedef struct packed {
        t_posd           p;
        logic            hit;
        logic            nneg;
        logic [PL_W-1:0] plh;
        logic [PL_W-1:0] pll;
        logic [PN_W-1:0] pah;
        logic [PN_W-1:0] pal;
        logic [PN_W-1:0] pbh;
        logic [PN_W-1:0] pbl;
    } t_se;

    typedef struct packed {
        t_posd p;
        logic  hit;
    } t_tg2;

    typedef struct packed {
        t_posd            p;
        logic             hit;
        logic             nneg;
        logic [DEN_W-1:0] den;
        logic [N2_W-1:0]  na;
        logic [N2_W-1:0]  nb;
    } t_sf;

    typedef struct packed {
        t_posd                 p;
        logic                  hit;
        logic                  nneg;
        logic [2:0][PR_W-1:0]  pra;
        logic [2:0][PR_W-1:0]  prb;
    } t_sg;

    function automatic logic [POS_W-1:0] sat32(logic [POS_W+2:0] v);
        logic [2:0] top;
        top = v[POS_W+2:POS_W];
        if (v[POS_W+2] && (top != 3'b111 || !v[POS_W-1])) begin
            return {1'b1, {(POS_W-1){1'b0}}};
        end else if (!v[POS_W+2] && (top != 3'b000 || v[POS_W-1])) begin
            return {1'b0, {(POS_W-1){1'b1}}};
        end
        return v[POS_W-1:0];
    endfunction

    logic en;
    logic r_skid_vld;
    t_rsp r_skid;

    logic r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld, r_f_vld, r_g_vld, r_o_vld;
    t_car r_a, n_a;
    t_sb  r_b, n_b;
    t_sc  r_c, n_c;
    t_sd  r_d, n_d;
    t_se  r_e, n_e;
    t_sf  r_f, n_f;
    t_sg  r_g, n_g;
    t_rsp r_o, n_o;

    logic             w_v1;
    logic [Q1_B-1:0]  w_q1;
    logic             w_ov1;
    t_tg1             w_t1;
    logic             w_va, w_vb;
    logic [Q2_B-1:0]  w_qa, w_qb;
    logic             w_ova, w_ovb;
    t_tg2             w_t2;
    logic             w_nneg;

    assign en          = !r_skid_vld;
    assign i_req.ready = en;

    // stage A: difference vector and rest length
    always_comb begin
        logic [2:0][POS_W-1:0] pa;
        logic [2:0][POS_W-1:0] pb;
        logic [DM_W:0]         d;
        logic [DM_W:0]         nd;
        pa = {i_req.data.a_pos_z, i_req.data.a_pos_y, i_req.data.a_pos_x};
        pb = {i_req.data.b_pos_z, i_req.data.b_pos_y, i_req.data.b_pos_x};
        n_a.mode = i_req.data.mode;
        n_a.rest = i_req.data.mode ? REST_W'(i_req.data.rod_length)
                 : REST_W'(i_req.data.a_radius) + REST_W'(i_req.data.b_radius);
        n_a.p.pa = pa;
        n_a.p.pb = pb;
        for (int i = 0; i < 3; i++) begin
            d  = {pb[i][POS_W-1], pb[i]} - {pa[i][POS_W-1], pa[i]};
            nd = (DM_W+1)'(0) - d;
            n_a.p.dn[i] = d[DM_W];
            n_a.p.dm[i] = d[DM_W] ? nd[DM_W-1:0] : d[DM_W-1:0];
        end
        n_a.ima = i_req.data.a_inv_mass;
        n_a.imb = i_req.data.b_inv_mass;
    end

    // stage B: squares
    always_comb begin
        n_b.c = r_a;
        for (int i = 0; i < 3; i++) begin
            n_b.sq[i] = (2*DM_W)'(r_a.p.dm[i]) * (2*DM_W)'(r_a.p.dm[i]);
        end
        n_b.rr = (2*REST_W)'(r_a.rest) * (2*REST_W)'(r_a.rest);
    end

    // stage C: squared distance and contact test
    always_comb begin
        logic [2*REST_W-1:0] rsq;
        rsq = r_b.rr >> F;
        n_c.c   = r_b.c;
        n_c.dsq = DSQ_W'(r_b.sq[0] >> F) + DSQ_W'(r_b.sq[1] >> F)
                + DSQ_W'(r_b.sq[2] >> F);
        n_c.dle = (2*REST_W)'(n_c.dsq) <= rsq;
    end

    cpcr_div #(
        .NW (N1_W),
        .DW (REST_W),
        .QB (Q1_B),
        .TW ($bits(t_tg1))
    ) u_div_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_c_vld),
        .i_num   ({r_c.dsq, {F{1'b0}}}),
        .i_den   (r_c.c.rest),
        .i_tag   ({r_c.c, r_c.dle}),
        .o_vld   (w_v1),
        .o_quot  (w_q1),
        .o_ovf   (w_ov1),
        .o_tag   (w_t1)
    );

    // stage D: length estimate and numerator
    always_comb begin
        logic [Q1_B:0]   quot;
        logic [Q1_B+1:0] lsum;
        logic [Q1_B:0]   lhalf;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] rest;
        quot  = w_ov1 ? ((Q1_B+1)'(1) << Q1_B) : {1'b0, w_q1};
        lsum  = (Q1_B+2)'(w_t1.c.rest) + (Q1_B+2)'(quot);
        lhalf = lsum[Q1_B+1:1];
        len   = (lhalf > (Q1_B+1)'(L_CAP)) ? L_CAP : lhalf[LEN_W-1:0];
        rest  = LEN_W'(w_t1.c.rest);
        n_d.p    = w_t1.c.p;
        n_d.len  = len;
        n_d.nneg = len < rest;
        n_d.nmag = (len < rest) ? rest - len : len - rest;
        n_d.hit  = (w_t1.c.rest != '0) && (w_t1.c.mode || (w_t1.dle && len <= rest));
        n_d.ima  = w_t1.c.ima;
        n_d.imb  = w_t1.c.imb;
        n_d.w    = IMW_W'(w_t1.c.ima) + IMW_W'(w_t1.c.imb);
    end

    // stage E: split products
    always_comb begin
        n_e.p    = r_d.p;
        n_e.hit  = r_d.hit;
        n_e.nneg = r_d.nneg;
        n_e.plh  = PL_W'(r_d.len[LEN_W-1:LL_W]) * PL_W'(r_d.w);
        n_e.pll  = PL_W'(r_d.len[LL_W-1:0]) * PL_W'(r_d.w);
        n_e.pah  = PN_W'(r_d.nmag[LEN_W-1:LL_W]) * PN_W'(r_d.ima);
        n_e.pal  = PN_W'(r_d.nmag[LL_W-1:0]) * PN_W'(r_d.ima);
        n_e.pbh  = PN_W'(r_d.nmag[LEN_W-1:LL_W]) * PN_W'(r_d.imb);
        n_e.pbl  = PN_W'(r_d.nmag[LL_W-1:0]) * PN_W'(r_d.imb);
    end

    // stage F: denominator and scale numerators
    always_comb begin
        logic [LW_W-1:0] lw;
        lw = (LW_W'(r_e.plh) << LL_W) + LW_W'(r_e.pll);
        n_f.p    = r_e.p;
        n_f.hit  = r_e.hit;
        n_f.nneg = r_e.nneg;
        n_f.den  = DEN_W'(lw >> F) + DEN_W'(EPS_RAW);
        n_f.na   = (N2_W'(r_e.pah) << LL_W) + N2_W'(r_e.pal);
        n_f.nb   = (N2_W'(r_e.pbh) << LL_W) + N2_W'(r_e.pbl);
    end

    cpcr_div #(
        .NW (N2_W),
        .DW (DEN_W),
        .QB (Q2_B),
        .TW ($bits(t_tg2))
    ) u_div_sa (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_f_vld),
        .i_num   (r_f.na),
        .i_den   (r_f.den),
        .i_tag   ({r_f.p, r_f.hit}),
        .o_vld   (w_va),
        .o_quot  (w_qa),
        .o_ovf   (w_ova),
        .o_tag   (w_t2)
    );

    cpcr_div #(
        .NW (N2_W),
        .DW (DEN_W),
        .QB (Q2_B),
        .TW (1)
    ) u_div_sb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_f_vld),
        .i_num   (r_f.nb),
        .i_den   (r_f.den),
        .i_tag   (r_f.nneg),
        .o_vld   (w_vb),
        .o_quot  (w_qb),
        .o_ovf   (w_ovb),
        .o_tag   (w_nneg)
    );

    // stage G: clamp scales, form correction products
    always_comb begin
        logic [Q2_B-1:0] sa;
        logic [Q2_B-1:0] sb;
        sa = (w_ova || w_qa > S_CAP) ? S_CAP : w_qa;
        sb = (w_ovb || w_qb > S_CAP) ? S_CAP : w_qb;
        n_g.p    = w_t2.p;
        n_g.hit  = w_t2.hit;
        n_g.nneg = w_nneg;
        for (int i = 0; i < 3; i++) begin
            n_g.pra[i] = PR_W'(sa) * PR_W'(w_t2.p.dm[i]);
            n_g.prb[i] = PR_W'(sb) * PR_W'(w_t2.p.dm[i]);
        end
    end

    // stage O: apply corrections with saturation
    always_comb begin
        logic [CORR_W-1:0]     cma;
        logic [CORR_W-1:0]     cmb;
        logic [POS_W+2:0]      ca;
        logic [POS_W+2:0]      cb;
        logic [2:0][POS_W-1:0] na;
        logic [2:0][POS_W-1:0] nb;
        for (int i = 0; i < 3; i++) begin
            cma = r_g.pra[i][F+CORR_W-1:F];
            cmb = r_g.prb[i][F+CORR_W-1:F];
            ca  = (r_g.nneg ^ r_g.p.dn[i]) ? (POS_W+3)'(0) - (POS_W+3)'(cma)
                                           : (POS_W+3)'(cma);
            cb  = (r_g.nneg ^ r_g.p.dn[i]) ? (POS_W+3)'(0) - (POS_W+3)'(cmb)
                                           : (POS_W+3)'(cmb);
            if (r_g.hit) begin
                na[i] = sat32({{3{r_g.p.pa[i][POS_W-1]}}, r_g.p.pa[i]} + ca);
                nb[i] = sat32({{3{r_g.p.pb[i][POS_W-1]}}, r_g.p.pb[i]} - cb);
            end else begin
                na[i] = r_g.p.pa[i];
                nb[i] = r_g.p.pb[i];
            end
        end
        n_o.new_a_x = na[0];
        n_o.new_a_y = na[1];
        n_o.new_a_z = na[2];
        n_o.new_b_x = nb[0];
        n_o.new_b_y = nb[1];
        n_o.new_b_z = nb[2];
        n_o.hit     = r_g.hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_req.valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= w_v1;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
            r_g_vld <= w_va & w_vb;
            r_o_vld <= r_g_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a <= n_a;
            r_b <= n_b;
            r_c <= n_c;
            r_d <= n_d;
            r_e <= n_e;
            r_f <= n_f;
            r_g <= n_g;
            r_o <= n_o;
        end
    end

    // skid: park the output word when it stalls while the pipe advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (o_rsp.ready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (r_o_vld && !o_rsp.ready) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld) begin
            r_skid <= r_o;
        end
    end

    assign o_rsp.valid = r_skid_vld | r_o_vld;
    assign o_rsp.data  = r_skid_vld ? r_skid : r_o;

    a_lanes_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_va == w_vb)
        else $error("scale divider lanes out of step");

    a_freeze_on_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |=> $stable(r_o_vld) && $stable(r_o))
        else $error("output stage moved while skid held a word");

    a_skid_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_o_vld) && !$past(o_rsp.ready))
        else $error("skid filled without a stalled output word");

endmodule
